### rtl/utf8sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 31;
    localparam int ST_W    = 3;
    localparam int TOTAL_W = 16;
    localparam int REM_W   = 3;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

    typedef enum logic [ST_W-1:0] {
        ST_CHAR     = 3'd0,
        ST_END      = 3'd1,
        ST_BAD_LEAD = 3'd2,
        ST_BAD_CONT = 3'd3,
        ST_TRUNC    = 3'd4
    } status_t;

    typedef struct packed {
        logic                valid;
        logic [CP_W-1:0]     code_point;
        status_t             status;
        logic [TOTAL_W-1:0]  char_total;
    } result_t;

endpackage

### rtl/utf8sd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_in_reg
// Input register: captures one byte per beat and holds it until the decode
// stage consumes it.
// ----------------------------------------------------------------------------
module utf8sd_in_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [utf8sd_pkg::BYTE_W-1:0] s_data_byte,
    input  logic                         take,
    output logic                         hold_valid,
    output logic [utf8sd_pkg::BYTE_W-1:0] hold_byte
);
    import utf8sd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

### rtl/utf8sd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_decode
// Decode stage: classifies the held byte against the sequence state, updates
// the accumulator, remaining count and character counter, and forms a result.
// ----------------------------------------------------------------------------
module utf8sd_decode #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  logic [utf8sd_pkg::BYTE_W-1:0] data_byte,
    output utf8sd_pkg::result_t           res
);
    import utf8sd_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [CP_W-1:0]       acc_reg;
    logic [CP_W-1:0]       acc_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CP_W-1:0]       shifted;

    function automatic logic [TOTAL_W-1:0] clamp_total(input logic [COUNT_BITS-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        return (wide > 32'(TOTAL_MAX)) ? TOTAL_MAX : wide[TOTAL_W-1:0];
    endfunction

    assign cnt_inc = (cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    assign shifted = {acc_reg[CP_W-7:0], data_byte[5:0]};

    always_comb begin
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res.valid      = 1'b0;
        res.code_point = '0;
        res.status     = ST_CHAR;
        res.char_total = clamp_total(cnt_reg);
        if (rem_reg == '0) begin
            if (data_byte == '0) begin
                acc_next  = '0;
                cnt_next  = '0;
                res.valid = 1'b1;
                res.status = ST_END;
            end else if (!data_byte[7]) begin
                acc_next       = '0;
                cnt_next       = cnt_inc;
                res.valid      = 1'b1;
                res.code_point = CP_W'(data_byte);
                res.char_total = clamp_total(cnt_inc);
            end else if (data_byte[7:5] == 3'b110) begin
                acc_next = CP_W'(data_byte[4:0]);
                rem_next = 3'd1;
            end else if (data_byte[7:4] == 4'b1110) begin
                acc_next = CP_W'(data_byte[3:0]);
                rem_next = 3'd2;
            end else if (data_byte[7:3] == 5'b11110) begin
                acc_next = CP_W'(data_byte[2:0]);
                rem_next = 3'd3;
            end else if (data_byte[7:2] == 6'b111110) begin
                acc_next = CP_W'(data_byte[1:0]);
                rem_next = 3'd4;
            end else if (data_byte[7:1] == 7'b1111110) begin
                acc_next = CP_W'(data_byte[0]);
                rem_next = 3'd5;
            end else begin
                acc_next   = '0;
                res.valid  = 1'b1;
                res.status = ST_BAD_LEAD;
            end
        end else if (data_byte == '0) begin
            acc_next   = '0;
            rem_next   = '0;
            res.valid  = 1'b1;
            res.status = ST_TRUNC;
        end else if (data_byte[7:6] != 2'b10) begin
            acc_next   = '0;
            rem_next   = '0;
            res.valid  = 1'b1;
            res.status = ST_BAD_CONT;
        end else if (rem_reg == 3'd1) begin
            acc_next       = '0;
            rem_next       = '0;
            cnt_next       = cnt_inc;
            res.valid      = 1'b1;
            res.code_point = shifted;
            res.char_total = clamp_total(cnt_inc);
        end else begin
            acc_next = shifted;
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (fire) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/utf8sd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_out_reg
// Result register: holds one decoded beat until the receiver takes it.
// ----------------------------------------------------------------------------
module utf8sd_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  utf8sd_pkg::result_t            res,
    output logic                           can_load,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [utf8sd_pkg::CP_W-1:0]    m_code_point,
    output logic [utf8sd_pkg::ST_W-1:0]    m_status,
    output logic [utf8sd_pkg::TOTAL_W-1:0] m_char_total
);
    import utf8sd_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [CP_W-1:0]    cp_reg;
    logic [ST_W-1:0]    st_reg;
    logic [TOTAL_W-1:0] total_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? res.valid : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.valid) begin
            cp_reg    <= res.code_point;
            st_reg    <= res.status;
            total_reg <= res.char_total;
        end
    end

    assign m_valid      = valid_reg;
    assign m_code_point = cp_reg;
    assign m_status     = st_reg;
    assign m_char_total = total_reg;

endmodule

### rtl/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream decoder (legacy one- to six-byte forms).
//
// Input channel s_*: one byte of the string per beat on s_data_byte.
// Result channel m_*: code point, status and running character total. A
// lead byte of a multi-byte sequence and inner continuation bytes give no
// beat; a finished character, a zero byte (end or truncation) or an error
// gives exactly one.
// An accepted byte waits in the input register, then its result goes to the
// result register, which drives m_valid. Throughput: one byte per cycle
// unless m_ready stalls; set by the single decode stage between the registers.
// Reset (aresetn low, synchronous) empties both registers, clears the
// accumulator, the character counter and returns to lead-byte state.
// When m_ready is low the result register holds its beat; the decode stage
// and then s_ready stall behind it, with one byte held in the input register.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [utf8sd_pkg::BYTE_W-1:0]  s_data_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [utf8sd_pkg::CP_W-1:0]    m_code_point,
    output logic [utf8sd_pkg::ST_W-1:0]    m_status,
    output logic [utf8sd_pkg::TOTAL_W-1:0] m_char_total
);
    import utf8sd_pkg::*;

    logic              hold_valid;
    logic [BYTE_W-1:0] hold_byte;
    logic              can_load;
    logic              fire;
    result_t           res;

    assign fire = hold_valid && can_load;

    utf8sd_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .take        (fire),
        .hold_valid  (hold_valid),
        .hold_byte   (hold_byte)
    );

    utf8sd_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .data_byte (hold_byte),
        .res       (res)
    );

    utf8sd_out_reg u_out_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (fire),
        .res          (res),
        .can_load     (can_load),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_status     (m_status),
        .m_char_total (m_char_total)
    );

endmodule

### tb/utf8_stream_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_checker
// Watches the byte input channel and the result channel of the UTF-8 stream
// decoder. Every accepted byte is run through a cycle-free decoder model
// that keeps its own accumulator, remaining-byte count and character count.
// Any result it produces is queued. Each result beat is compared field by
// field against the oldest queued result. The mismatch count and the number
// of results still outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [utf8sd_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [utf8sd_pkg::CP_W-1:0]    m_code_point,
    input  logic [utf8sd_pkg::ST_W-1:0]    m_status,
    input  logic [utf8sd_pkg::TOTAL_W-1:0] m_char_total,
    output int                             fail_count,
    output int                             pending_count
);
    import utf8sd_pkg::*;

    localparam longint unsigned CHAR_CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct {
        logic [CP_W-1:0]    code_point;
        status_t            status;
        logic [TOTAL_W-1:0] char_total;
    } decoded_t;

    decoded_t           decoded_q[$];
    decoded_t           want;
    logic [CP_W-1:0]    acc;
    logic [REM_W-1:0]   rem;
    logic [31:0]        char_cnt;
    int                 mismatches = 0;
    int                 outstanding = 0;

    assign fail_count    = mismatches;
    assign pending_count = outstanding;

    function automatic logic [TOTAL_W-1:0] clamped_total();
        return (char_cnt > 32'(TOTAL_MAX)) ? TOTAL_MAX : char_cnt[TOTAL_W-1:0];
    endfunction

    function automatic void post_result(input logic [CP_W-1:0] cp, input status_t st);
        decoded_t r;
        r.code_point = cp;
        r.status     = st;
        r.char_total = clamped_total();
        decoded_q.push_back(r);
    endfunction

    function automatic void bump_char_cnt();
        if (64'(char_cnt) < CHAR_CNT_MAX)
            char_cnt = char_cnt + 32'd1;
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        if (rem == '0) begin
            if (b == 8'h00) begin
                post_result('0, ST_END);
                char_cnt = '0;
                acc      = '0;
            end else if (b[7] == 1'b0) begin
                acc = '0;
                bump_char_cnt();
                post_result(CP_W'(b), ST_CHAR);
            end else if (b[7:5] == 3'b110) begin
                acc = CP_W'(b[4:0]);
                rem = 3'd1;
            end else if (b[7:4] == 4'b1110) begin
                acc = CP_W'(b[3:0]);
                rem = 3'd2;
            end else if (b[7:3] == 5'b11110) begin
                acc = CP_W'(b[2:0]);
                rem = 3'd3;
            end else if (b[7:2] == 6'b111110) begin
                acc = CP_W'(b[1:0]);
                rem = 3'd4;
            end else if (b[7:1] == 7'b1111110) begin
                acc = CP_W'(b[0]);
                rem = 3'd5;
            end else begin
                acc = '0;
                post_result('0, ST_BAD_LEAD);
            end
        end else if (b == 8'h00) begin
            acc = '0;
            rem = '0;
            post_result('0, ST_TRUNC);
        end else if (b[7:6] != 2'b10) begin
            acc = '0;
            rem = '0;
            post_result('0, ST_BAD_CONT);
        end else begin
            acc = {acc[CP_W-7:0], b[5:0]};
            rem = rem - 3'd1;
            if (rem == '0) begin
                bump_char_cnt();
                post_result(acc, ST_CHAR);
                acc = '0;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $display("%0t: %s mismatch, expected %h, got %h",
                     $time, name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            acc      = '0;
            rem      = '0;
            char_cnt = '0;
            decoded_q.delete();
        end else begin
            if (s_valid && s_ready)
                decode_byte(s_data_byte);
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h %h %h",
                             $time, m_code_point, m_status, m_char_total);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("code_point", 32'(want.code_point), 32'(m_code_point));
                    check_field("status", 32'(want.status), 32'(m_status));
                    check_field("char_total", 32'(want.char_total), 32'(m_char_total));
                end
            end
        end
        outstanding <= decoded_q.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the UTF-8 stream decoder testbench. Drives a directed byte string
// covering every sequence length, the code point extremes and each error
// kind, then a short run of ASCII that builds up the character count, then
// random strings made mostly of well-formed sequences with noise, truncated
// and broken sequences mixed in. Both channels stall at random. The checker
// does all prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import utf8sd_pkg::*;

    localparam int COUNT_BITS   = 16;
    localparam int RANDOM_ITEMS = 1400;
    localparam int SAT_ITEMS    = 200;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CP_W-1:0]      m_code_point;
    logic [ST_W-1:0]      m_status;
    logic [TOTAL_W-1:0]   m_char_total;
    int                   fail_count;
    int                   pending_count;
    bit                   idle_on = 1'b1;
    int                   sent = 0;

    utf8_stream_decoder_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_status     (m_status),
        .m_char_total (m_char_total)
    );

    utf8_stream_decoder_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_status      (m_status),
        .m_char_total  (m_char_total),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 8);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (idle_on && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    function automatic logic [BYTE_W-1:0] lead_of(input int len);
        case (len)
            1:       return BYTE_W'($urandom_range(1, 127));
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            4:       return {5'b11110, 3'($urandom)};
            5:       return {6'b111110, 2'($urandom)};
            default: return {7'b1111110, 1'($urandom)};
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [BYTE_W-1:0] bad_cont_byte();
        int r;
        r = $urandom_range(1, 191);
        return (r < 128) ? BYTE_W'(r) : BYTE_W'(r + 64);
    endfunction

    function automatic int pick_len();
        return ($urandom_range(99) < 40) ? 1 : $urandom_range(2, 6);
    endfunction

    task automatic send_random_seq();
        int sel;
        int len;
        int k;
        sel = $urandom_range(99);
        if (sel < 70) begin
            len = pick_len();
            send_byte(lead_of(len));
            repeat (len - 1) send_byte(cont_byte());
        end else if (sel < 76) begin
            send_byte(8'h00);
        end else if (sel < 86) begin
            send_byte(BYTE_W'($urandom));
        end else begin
            len = $urandom_range(2, 6);
            k = $urandom_range(0, len - 2);
            send_byte(lead_of(len));
            repeat (k) send_byte(cont_byte());
            send_byte((sel < 93) ? 8'h00 : bad_cont_byte());
        end
    endtask

    task automatic send_string(input logic [BYTE_W-1:0] s[]);
        foreach (s[i]) send_byte(s[i]);
    endtask

    initial begin
        logic [BYTE_W-1:0] directed[];
        int                stop_at;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // end with empty count, ascii, one to six byte forms, overlong,
        // max code point, bad leads, truncation, bad continuation
        directed = '{8'h00, 8'h41, 8'hC2, 8'h80, 8'hE0, 8'h80, 8'h80,
                     8'hF0, 8'h90, 8'h80, 8'h80,
                     8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                     8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                     8'h80, 8'hFE, 8'hFF, 8'hE2, 8'h00, 8'hC3, 8'h41, 8'h00};
        send_string(directed);

        // ascii run, then a bad lead and an end with a large count
        repeat (SAT_ITEMS) send_byte(BYTE_W'($urandom_range(1, 127)));
        send_byte(8'hFF);
        send_byte(8'h00);
        drain();

        stop_at = sent + RANDOM_ITEMS;
        while (sent < stop_at) begin
            idle_on = !(sent > stop_at - 1200 && sent < stop_at - 800);
            if (sent > stop_at - 600 && sent < stop_at - 590)
                drain();
            send_random_seq();
        end
        idle_on = 1'b1;

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### utf8_stream_decoder_unit.f
rtl/utf8sd_pkg.sv
rtl/utf8sd_in_reg.sv
rtl/utf8sd_decode.sv
rtl/utf8sd_out_reg.sv
rtl/utf8_stream_decoder_unit.sv
tb/utf8_stream_decoder_checker.sv
tb/tb.sv
